FILE: rtl/core/lpmr_pkg.sv
package lpmr_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int RESERVED_DEF   = 8;
  localparam int HDR_BYTES      = 4;
  localparam int RS_W           = 13;
  localparam logic [RS_W-1:0] RS_RESET = 13'd4096;
  localparam int CFG_AW         = 3;
  localparam logic REG_RING_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_APP_START,
    OP_APP_BYTE,
    OP_POP_START,
    OP_POP_BYTE
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FAIL,
    STAT_NOSPACE,
    STAT_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    OPEN_NONE,
    OPEN_APPEND,
    OPEN_POP
  } open_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_WR,
    S_HDR_RD,
    S_HDR_CHK,
    S_BYTE_RD
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [12:0] length_out;
    logic [7:0]  data_out;
    logic        last;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

endpackage

FILE: rtl/core/lpmr_ram.sv
module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/lpmr_fifo.sv
module lpmr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] data_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = data_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/lpmr_front.sv
module lpmr_front
  import lpmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_data_byte,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  item_t             in_item;
  logic [ITEM_W-1:0] q_data;
  logic              q_empty;

  always_comb begin
    in_item.op        = op_t'(in_mode);
    in_item.length    = in_length;
    in_item.data_byte = in_data_byte;
  end

  lpmr_fifo #(.WIDTH(ITEM_W)) u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (in_item),
    .full    (full),
    .pop     (item_take),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  assign item_valid = !q_empty;
  assign item       = item_t'(q_data);

endmodule

FILE: rtl/core/lpmr_back.sv
module lpmr_back
  import lpmr_pkg::*;
#(
  parameter int RING_DEPTH     = RING_DEPTH_DEF,
  parameter int RESERVED_BYTES = RESERVED_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [RS_W-1:0] ring_size,
  input  logic            cfg_clr,
  input  logic            item_valid,
  input  item_t           item,
  output logic            item_take,
  input  logic            res_full,
  output logic            res_push,
  output res_t            res
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = AW + 1;
  localparam int CW = (SW > 17 ? SW : 17) + 1;

  function automatic logic [AW-1:0] wrap1(input logic [AW-1:0] p, input logic [SW-1:0] sz);
    logic [SW-1:0] q;
    q = {1'b0, p} + SW'(1);
    wrap1 = (q == sz) ? '0 : q[AW-1:0];
  endfunction

  state_t        state_r, state_nxt;
  open_t         open_r, open_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] wcur_r, wcur_nxt;
  logic [AW-1:0] rcur_r, rcur_nxt;
  logic [SW-1:0] wleft_r, wleft_nxt;
  logic [SW-1:0] rleft_r, rleft_nxt;
  logic [SW-1:0] used_r, used_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [31:0]   hdr_r, hdr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          last_r, last_nxt;

  logic [SW-1:0] s;
  logic [SW-1:0] fr;
  logic [CW-1:0] fr_net;
  logic [CW-1:0] need;
  logic [SW-1:0] used;
  logic [31:0]   skip;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  lpmr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (32'(ring_size) > 32'(RING_DEPTH)) begin
      s = SW'(RING_DEPTH);
    end else begin
      s = SW'(ring_size);
    end
    if (head_r == tail_r) begin
      fr = s;
    end else if (head_r > tail_r) begin
      fr = {1'b0, head_r} - {1'b0, tail_r};
    end else begin
      fr = {1'b0, head_r} + s - {1'b0, tail_r};
    end
    fr_net = (CW'(fr) > CW'(RESERVED_BYTES)) ? CW'(fr) - CW'(RESERVED_BYTES) : '0;
    need   = CW'(item.length) + CW'(HDR_BYTES);
    if (tail_r >= head_r) begin
      used = {1'b0, tail_r} - {1'b0, head_r};
    end else begin
      used = {1'b0, tail_r} + s - {1'b0, head_r};
    end
    // skip target for a message the caller cannot hold
    skip = 32'(rcur_r) + hdr_r;
    if (skip >= 32'(s)) begin
      skip = skip - 32'(s);
    end
  end

  always_comb begin
    state_nxt = state_r;
    open_nxt  = open_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    wcur_nxt  = wcur_r;
    rcur_nxt  = rcur_r;
    wleft_nxt = wleft_r;
    rleft_nxt = rleft_r;
    used_nxt  = used_r;
    len_nxt   = len_r;
    hdr_nxt   = hdr_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    item_take = 1'b0;
    res_push  = 1'b0;
    res       = '{status: STAT_FAIL, length_out: '0, data_out: '0, last: 1'b0};
    mem_we    = 1'b0;
    mem_waddr = wcur_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rcur_r;

    case (state_r)
      S_IDLE: begin
        if (item_valid && !res_full) begin
          item_take = 1'b1;
          case (item.op)
            OP_APP_START: begin
              res_push = 1'b1;
              open_nxt = OPEN_NONE;
              if (s != '0 && item.length != '0) begin
                if (fr_net == '0 || need > fr_net) begin
                  res.status = STAT_NOSPACE;
                end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = tail_r;
                  mem_wdata  = item.length[7:0];
                  wcur_nxt   = wrap1(tail_r, s);
                  wleft_nxt  = SW'(item.length);
                  len_nxt    = item.length;
                  open_nxt   = OPEN_APPEND;
                  cnt_nxt    = 2'd1;
                  state_nxt  = S_HDR_WR;
                  res.status = STAT_OK;
                end
              end
            end
            OP_APP_BYTE: begin
              res_push = 1'b1;
              if (open_r == OPEN_APPEND && s != '0 && wleft_r != '0
                  && {1'b0, wcur_r} < s) begin
                mem_we     = 1'b1;
                mem_wdata  = item.data_byte;
                wcur_nxt   = wrap1(wcur_r, s);
                wleft_nxt  = wleft_r - SW'(1);
                res.status = STAT_OK;
                if (wleft_r == SW'(1)) begin
                  tail_nxt = wrap1(wcur_r, s);
                  open_nxt = OPEN_NONE;
                  res.last = 1'b1;
                end
              end
            end
            OP_POP_START: begin
              open_nxt = OPEN_NONE;
              if (item.length != '0 && s != '0) begin
                if (head_r == tail_r) begin
                  res_push   = 1'b1;
                  res.status = STAT_EMPTY;
                end else if (used < SW'(HDR_BYTES)) begin
                  res_push = 1'b1;
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = head_r;
                  rcur_nxt  = wrap1(head_r, s);
                  used_nxt  = used;
                  len_nxt   = item.length;
                  cnt_nxt   = 2'd0;
                  state_nxt = S_HDR_RD;
                end
              end else begin
                res_push = 1'b1;
              end
            end
            OP_POP_BYTE: begin
              if (open_r == OPEN_POP && s != '0 && rleft_r != '0
                  && {1'b0, rcur_r} < s) begin
                mem_re    = 1'b1;
                rcur_nxt  = wrap1(rcur_r, s);
                rleft_nxt = rleft_r - SW'(1);
                last_nxt  = 1'b0;
                if (rleft_r == SW'(1)) begin
                  head_nxt = wrap1(rcur_r, s);
                  open_nxt = OPEN_NONE;
                  last_nxt = 1'b1;
                end
                state_nxt = S_BYTE_RD;
              end else begin
                res_push = 1'b1;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_HDR_WR: begin
        // header bytes two and three are always zero
        mem_we    = 1'b1;
        mem_wdata = (cnt_r == 2'd1) ? len_r[15:8] : 8'd0;
        wcur_nxt  = wrap1(wcur_r, s);
        cnt_nxt   = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_IDLE;
        end
      end
      S_HDR_RD: begin
        hdr_nxt[8*cnt_r +: 8] = mem_rdata;
        if (cnt_r == 2'd3) begin
          state_nxt = S_HDR_CHK;
        end else begin
          mem_re   = 1'b1;
          rcur_nxt = wrap1(rcur_r, s);
          cnt_nxt  = cnt_r + 2'd1;
        end
      end
      S_HDR_CHK: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
        if (hdr_r == '0 || hdr_r > 32'(used_r) - 32'(HDR_BYTES)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (32'(len_r) < hdr_r) begin
          head_nxt = skip[AW-1:0];
        end else begin
          rleft_nxt      = hdr_r[SW-1:0];
          open_nxt       = OPEN_POP;
          res.status     = STAT_OK;
          res.length_out = hdr_r[12:0];
        end
      end
      S_BYTE_RD: begin
        res_push     = 1'b1;
        res.status   = STAT_OK;
        res.data_out = mem_rdata;
        res.last     = last_r;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_clr) begin
      head_nxt = '0;
      tail_nxt = '0;
      open_nxt = OPEN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      open_r  <= OPEN_NONE;
      head_r  <= '0;
      tail_r  <= '0;
      wcur_r  <= '0;
      rcur_r  <= '0;
      wleft_r <= '0;
      rleft_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      wcur_r  <= wcur_nxt;
      rcur_r  <= rcur_nxt;
      wleft_r <= wleft_nxt;
      rleft_r <= rleft_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    used_r <= used_nxt;
    len_r  <= len_nxt;
    hdr_r  <= hdr_nxt;
    last_r <= last_nxt;
  end

endmodule

FILE: rtl/core/length_prefixed_message_ring_top.sv
// Message ring: requests enter a two-deep queue, are carried out one at a time against a
// byte ring memory (one write and one registered read per cycle), and their results
// wait in a two-deep queue. Append byte is one memory write; pop byte reads the memory
// and returns the registered byte; append start writes the four header bytes; pop start
// reads the four header bytes and then checks the header. Writing ring_size empties the ring.
module length_prefixed_message_ring_top
  import lpmr_pkg::*;
#(
  parameter int RING_DEPTH     = RING_DEPTH_DEF,
  parameter int RESERVED_BYTES = RESERVED_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_mode,
  input  logic [15:0]       in_length,
  input  logic [7:0]        in_data_byte,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        out_status,
  output logic [12:0]       out_length_out,
  output logic [7:0]        out_data_out,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [RS_W-1:0]  ring_size_r;
  logic             cfg_clr;
  logic             item_valid;
  item_t            item;
  logic             item_take;
  logic             res_push;
  res_t             res;
  logic             res_full;
  logic [RES_W-1:0] res_q;
  res_t             res_out;

  assign pready  = 1'b1;
  assign cfg_clr = psel && penable && pwrite && (paddr[2] == REG_RING_SIZE);
  assign prdata  = (paddr[2] == REG_RING_SIZE) ? 32'(ring_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RS_RESET;
    end else if (cfg_clr) begin
      ring_size_r <= pwdata[RS_W-1:0];
    end
  end

  lpmr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_length    (in_length),
    .in_data_byte (in_data_byte),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  lpmr_back #(
    .RING_DEPTH     (RING_DEPTH),
    .RESERVED_BYTES (RESERVED_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ring_size  (ring_size_r),
    .cfg_clr    (cfg_clr),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  lpmr_fifo #(.WIDTH(RES_W)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign res_out        = res_t'(res_q);
  assign out_status     = res_out.status;
  assign out_length_out = res_out.length_out;
  assign out_data_out   = res_out.data_out;
  assign out_last       = res_out.last;

`ifndef NO_ASSERTIONS
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overflow");

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> item_valid)
    else $error("request taken from empty queue");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> empty)
    else $error("results present after reset");
`endif

endmodule

FILE: tb/length_prefixed_message_ring_top_tb.sv
`timescale 1ns / 1ps

module length_prefixed_message_ring_top_tb;
  import lpmr_pkg::*;

  localparam int DEPTH = 4096;
  localparam int RESERVE = 8;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    status_t     status;
    logic [12:0] length_out;
    logic [7:0]  data_out;
    logic        last;
  } ring_result_t;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic [1:0] in_mode;
  logic [15:0] in_length;
  logic [7:0] in_data_byte;
  logic empty;
  logic pop;
  logic [1:0] out_status;
  logic [12:0] out_length_out;
  logic [7:0] out_data_out;
  logic out_last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  length_prefixed_message_ring_top uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_mode(in_mode), .in_length(in_length), .in_data_byte(in_data_byte),
    .empty(empty), .pop(pop), .out_status(out_status), .out_length_out(out_length_out),
    .out_data_out(out_data_out), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ring predictor state
  logic [7:0] ring_mem [0:DEPTH-1];
  int ring_sz;
  int head_ptr, tail_ptr, wr_cur, wr_left, rd_cur, rd_left;
  open_t op_state;

  ring_result_t expected_results[$];
  int fail_count;
  int items_sent;
  int results_seen;
  int cycle_count;
  int snd_idle, rcv_idle;
  int hold_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int eff_size();
    return (ring_sz > DEPTH) ? DEPTH : ring_sz;
  endfunction

  function automatic int free_space(input int s);
    int f;
    if (head_ptr == tail_ptr) f = s;
    else if (head_ptr > tail_ptr) f = head_ptr - tail_ptr;
    else f = head_ptr + s - tail_ptr;
    return (f > RESERVE) ? f - RESERVE : 0;
  endfunction

  task automatic clear_ring();
    head_ptr = 0;
    tail_ptr = 0;
    op_state = OPEN_NONE;
  endtask

  task automatic predict_ring(input op_t m, input logic [15:0] len, input logic [7:0] b);
    int s, fr, used, hdr, p;
    ring_result_t r;
    s = eff_size();
    r.status = STAT_FAIL;
    r.length_out = '0;
    r.data_out = '0;
    r.last = 1'b0;
    case (m)
      OP_APP_START: begin
        op_state = OPEN_NONE;
        if (s != 0 && len != 0) begin
          fr = free_space(s);
          if (fr == 0 || HDR_BYTES + int'(len) > fr) begin
            r.status = STAT_NOSPACE;
          end else begin
            p = tail_ptr;
            for (int i = 0; i < HDR_BYTES; i++) begin
              ring_mem[p] = (i < 2) ? 8'(len >> (8 * i)) : 8'd0;
              p = (p + 1) % s;
            end
            wr_cur = p;
            wr_left = len;
            op_state = OPEN_APPEND;
            r.status = STAT_OK;
          end
        end
      end
      OP_APP_BYTE: begin
        if (op_state == OPEN_APPEND && s != 0 && wr_left != 0 && wr_cur < s) begin
          ring_mem[wr_cur] = b;
          wr_cur = (wr_cur + 1) % s;
          wr_left--;
          if (wr_left == 0) begin
            tail_ptr = wr_cur;
            op_state = OPEN_NONE;
            r.last = 1'b1;
          end
          r.status = STAT_OK;
        end
      end
      OP_POP_START: begin
        op_state = OPEN_NONE;
        if (len != 0 && s != 0) begin
          if (head_ptr == tail_ptr) begin
            r.status = STAT_EMPTY;
          end else begin
            used = (tail_ptr >= head_ptr) ? tail_ptr - head_ptr : tail_ptr + s - head_ptr;
            if (used < HDR_BYTES) begin
              clear_ring();
            end else begin
              hdr = 0;
              p = head_ptr;
              for (int i = 0; i < HDR_BYTES; i++) begin
                hdr |= int'(ring_mem[p]) << (8 * i);
                p = (p + 1) % s;
              end
              if (hdr == 0 || hdr > used - HDR_BYTES) begin
                clear_ring();
              end else if (int'(len) < hdr) begin
                head_ptr = (p + hdr) % s;
              end else begin
                rd_cur = p;
                rd_left = hdr;
                op_state = OPEN_POP;
                r.status = STAT_OK;
                r.length_out = 13'(hdr);
              end
            end
          end
        end
      end
      default: begin
        if (op_state == OPEN_POP && s != 0 && rd_left != 0 && rd_cur < s) begin
          r.data_out = ring_mem[rd_cur];
          rd_cur = (rd_cur + 1) % s;
          rd_left--;
          if (rd_left == 0) begin
            head_ptr = rd_cur;
            op_state = OPEN_NONE;
            r.last = 1'b1;
          end
          r.status = STAT_OK;
        end
      end
    endcase
    expected_results.push_back(r);
  endtask

  // inputs change on the falling edge; the request is taken at the first rising edge without full
  task automatic send_req(input op_t m, input logic [15:0] len, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_mode = m;
    in_length = len;
    in_data_byte = b;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    predict_ring(m, len, b);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    push = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_ring_size(input int v);
    wait_drain();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_AW'(REG_RING_SIZE) << 2;
    pwdata = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    ring_sz = v & 32'h1FFF;
    clear_ring();
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // result side: pop decided at the falling edge, result checked at the rising edge
  initial begin
    ring_result_t exp_r;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(0, 99) >= rcv_idle);
      end
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d", out_status);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fail_count++;
          end
          if (out_length_out !== exp_r.length_out) begin
            $error("length_out: expected %0d, got %0d", exp_r.length_out, out_length_out);
            fail_count++;
          end
          if (out_data_out !== exp_r.data_out) begin
            $error("data_out: expected %0d, got %0d", exp_r.data_out, out_data_out);
            fail_count++;
          end
          if (out_last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_last);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic append_msg(input int len, input int nbytes);
    send_req(OP_APP_START, 16'(len), 8'($urandom));
    if (op_state == OPEN_APPEND) begin
      for (int i = 0; i < nbytes; i++) send_req(OP_APP_BYTE, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic pop_msg(input logic [15:0] cap, input bit partial);
    int n;
    send_req(OP_POP_START, cap, 8'($urandom));
    if (op_state == OPEN_POP) begin
      n = partial ? $urandom_range(0, rd_left) : rd_left;
      for (int i = 0; i < n; i++) send_req(OP_POP_BYTE, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_directed();
    send_req(OP_POP_START, 16'd5, 8'd0);        // empty queue
    send_req(OP_POP_START, 16'd0, 8'd0);        // zero capacity
    send_req(OP_APP_START, 16'd0, 8'd0);        // zero-length append
    send_req(OP_APP_BYTE, 16'd0, 8'hFF);        // byte with nothing open
    send_req(OP_POP_BYTE, 16'hFFFF, 8'd0);
    send_req(OP_APP_START, 16'hFFFF, 8'd0);     // no room
    send_req(OP_APP_START, 16'd3, 8'd0);
    send_req(OP_APP_BYTE, 16'd0, 8'h00);
    send_req(OP_APP_BYTE, 16'd0, 8'hFF);
    send_req(OP_APP_BYTE, 16'd0, 8'hA5);
    send_req(OP_POP_START, 16'd2, 8'd0);        // capacity too small, message skipped
    send_req(OP_APP_START, 16'd2, 8'd0);
    send_req(OP_APP_BYTE, 16'd0, 8'h5A);
    send_req(OP_APP_BYTE, 16'd0, 8'hC3);
    send_req(OP_APP_START, 16'd4, 8'd0);        // abandoned by the next start
    send_req(OP_POP_START, 16'hFFFF, 8'd0);
    send_req(OP_APP_BYTE, 16'd0, 8'h11);        // append no longer open
    send_req(OP_POP_BYTE, 16'd0, 8'd0);
    send_req(OP_POP_BYTE, 16'd0, 8'd0);
    send_req(OP_POP_BYTE, 16'd0, 8'd0);
    write_ring_size(0);
    send_req(OP_APP_START, 16'd1, 8'd0);        // zero ring size
    send_req(OP_POP_START, 16'd1, 8'd0);
    write_ring_size(RESERVE);
    send_req(OP_APP_START, 16'd1, 8'd0);        // reserve leaves no room
  endtask

  task automatic test_random(input int n_items, input int big_len);
    int r, len;
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 24) : $urandom_range(1, big_len);
        append_msg(len, ($urandom_range(0, 99) < 6) ? $urandom_range(0, len) : len);
      end else if (r < 88) begin
        case ($urandom_range(0, 3))
          0: pop_msg(16'($urandom_range(0, 30)), 1'b0);
          1: pop_msg(16'hFFFF, $urandom_range(0, 99) < 6);
          default: pop_msg(16'($urandom_range(1, 4200)), 1'b0);
        endcase
      end else begin
        send_req(op_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // receiver stops for a long stretch while requests keep coming, then the sender waits it out
  task automatic test_backpressure();
    @(negedge clk);
    push = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 10; i++) append_msg(3, 3);
    for (int i = 0; i < 10; i++) pop_msg(16'hFFFF, 1'b0);
    wait_drain();
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_mode = OP_APP_START;
    in_length = '0;
    in_data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    cycle_count = 0;
    hold_cycles = 0;
    snd_idle = 36;
    rcv_idle = 52;
    ring_sz = RS_RESET;
    head_ptr = 0;
    tail_ptr = 0;
    wr_cur = 0;
    wr_left = 0;
    rd_cur = 0;
    rd_left = 0;
    op_state = OPEN_NONE;
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    write_ring_size(13'h1FFF);
    test_random(450, 300);
    test_backpressure();

    snd_idle = 52;
    rcv_idle = 36;
    write_ring_size(64);
    test_random(350, 64);
    write_ring_size(DEPTH);
    test_random(300, 200);

    snd_idle = 0;
    rcv_idle = 0;
    write_ring_size(23);
    test_random(200, 23);
    write_ring_size(300);
    test_random(350, 300);
    test_backpressure();

    wait_drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests and %0d results over ring sizes 0 to 8191,",
             items_sent, results_seen);
    $display("with random gaps on both sides, long receiver stalls and drained pauses");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
